// File: rtl/core/rpbf_pkg.sv
// ----------------------------------------------------------------------------
// rpbf_pkg
// Shared constants for the radial pair bin finder.
// ----------------------------------------------------------------------------
package rpbf_pkg;

  localparam int MaxPointsDef = 4096;
  localparam int MaskLanesDef = 64;
  localparam int FracBitsDef  = 16;

  localparam int CoordW    = 32;
  localparam int IndexW    = 12;
  localparam int GroupW    = 6;
  localparam int MaskW     = 64;
  localparam int ResultCap = 64;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegRmin = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRmax = 1'b1;

endpackage

// File: rtl/core/radial_pair_bin_finder.sv
// Each point is handled one group of MASK_LANES earlier points at a time: row read,
// squares, compare, result beat; output stalls hold the sequence. A first point or a
// dropped point gives a single result beat. in_stall stays high until the point is done.
// Reset clears the point count and sets r_min = 0, r_max = 1.0, not the memory.
// ----------------------------------------------------------------------------
// radial_pair_bin_finder
// Stores 3D points and reports earlier points within a radial bin as masks.
// ----------------------------------------------------------------------------
module radial_pair_bin_finder
  import rpbf_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int MASK_LANES = MaskLanesDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic signed [CoordW-1:0] pos_z,
  input  logic                     new_set,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IndexW-1:0]        point_index,
  output logic [GroupW-1:0]        group_number,
  output logic [MaskW-1:0]         match_mask,
  output logic                     last_in_run,
  output logic                     store_full
);

  localparam int Rows   = MAX_POINTS / MASK_LANES;
  localparam int RowW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int LaneW  = $clog2(MASK_LANES);
  localparam int CntW   = $clog2(MAX_POINTS) + 1;
  localparam int NgW    = $clog2(ResultCap) + 1;
  localparam logic [31:0] RminZero = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_SUM, S_OUT, S_WRITE} state_t;
  typedef logic [3*CoordW-1:0] point_t;

  // One row holds MASK_LANES points; lane k of row g is point g*LANES+k.
  point_t mem [Rows][MASK_LANES];

  state_t state;
  logic [31:0] r_min, r_max;
  logic [CntW-1:0] point_count;
  logic [CntW-1:0] j;
  logic signed [CoordW-1:0] px, py, pz;
  logic [NgW-1:0] ngroups;
  logic [GroupW:0] grp;
  logic [63:0] lo2, hi2;
  logic empty;
  point_t rd_row [MASK_LANES];
  logic [63:0] sq [MASK_LANES][3];
  logic [MaskW-1:0] mask_next;

  // Read port, one row per cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MASK_LANES; k++) begin
      rd_row[k] <= mem[RowW'(grp)][k];
    end
    if (state == S_WRITE) begin
      mem[RowW'(j >> LaneW)][j[LaneW-1:0]] <= {px, py, pz};
    end
  end

  // Squared differences, registered per lane and axis.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MASK_LANES; k++) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [CoordW:0] d;
        logic [CoordW:0] m;
        d = $signed({rd_row[k][CoordW*(2-a) + CoordW-1], rd_row[k][CoordW*(2-a) +: CoordW]})
          - $signed({(a == 0) ? px[CoordW-1] : (a == 1) ? py[CoordW-1] : pz[CoordW-1],
                     (a == 0) ? px : (a == 1) ? py : pz});
        m = d[CoordW] ? (CoordW+1)'(-d) : d[CoordW:0];
        sq[k][a] <= 64'(m) * 64'(m);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MASK_LANES; k++) begin
      logic [65:0] t;
      logic [CntW-1:0] idx;
      t = 66'(sq[k][0]) + 66'(sq[k][1]) + 66'(sq[k][2]);
      idx = (CntW'(grp) << LaneW) | CntW'(k);
      mask_next[k] = !empty && (idx < j) && (t[65:64] == 2'b00)
                     && (t[63:0] >= lo2) && (t[63:0] < hi2);
    end
    for (int k = MASK_LANES; k < MaskW; k++) mask_next[k] = 1'b0;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      r_min       <= '0;
      r_max       <= 32'd65536;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegRmin: r_min <= cfg_data;
          RegRmax: r_max <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            logic [CntW-1:0] c;
            logic [31:0] rmn;
            c = new_set ? '0 : point_count;
            rmn = (r_min == 32'd0) ? RminZero : r_min;
            px <= pos_x; py <= pos_y; pz <= pos_z;
            j <= c;
            grp <= '0;
            lo2 <= 64'(rmn) * 64'(rmn);
            hi2 <= 64'(r_max) * 64'(r_max);
            empty <= rmn >= r_max;
            point_count <= c;
            if (c == CntW'(MAX_POINTS)) begin
              point_index <= '0; group_number <= '0; match_mask <= '0;
              last_in_run <= 1'b1; store_full <= 1'b1; out_valid <= 1'b1;
              state <= S_OUT;
            end else if (c == '0) begin
              point_index <= '0; group_number <= '0; match_mask <= '0;
              last_in_run <= 1'b1; store_full <= 1'b0; out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              ngroups <= ((c + CntW'(MASK_LANES-1)) >> LaneW) > CntW'(ResultCap)
                         ? NgW'(ResultCap) : NgW'((c + CntW'(MASK_LANES-1)) >> LaneW);
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP:  state <= S_SUM;
        S_SUM: begin
          point_index  <= j[IndexW-1:0];
          group_number <= grp[GroupW-1:0];
          match_mask   <= mask_next;
          last_in_run  <= (NgW'(grp) + 1'b1 == ngroups);
          store_full   <= 1'b0;
          out_valid    <= 1'b1;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (store_full) state <= S_IDLE;
            else if (last_in_run) state <= S_WRITE;
            else begin
              grp <= grp + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          point_count <= j + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_full_mask_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_full |-> match_mask == '0 && last_in_run)
    else $error("full-store beat carries a mask");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CntW'(MAX_POINTS)) else $error("point count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_mask))
    else $error("stalled result changed");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radial_pair_bin_finder: streams 3D points, predicts
// the per-group match masks of each point and compares every result beat.
// ----------------------------------------------------------------------------
module tb
  import rpbf_pkg::*;
();

  localparam int NPoints  = MaxPointsDef;
  localparam int Lanes    = MaskLanesDef;
  localparam int RminZero = ((1 << FracBitsDef) + 500) / 1000;
  localparam int Stall    = 6000;

  typedef struct {
    logic [IndexW-1:0] point_index;
    logic [GroupW-1:0] group_number;
    logic [MaskW-1:0]  match_mask;
    logic              last_in_run;
    logic              store_full;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegRmin;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CoordW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic new_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IndexW-1:0] point_index;
  logic [GroupW-1:0] group_number;
  logic [MaskW-1:0] match_mask;
  logic last_in_run, store_full;

  // Shadow of the block's point store and radius registers.
  logic [31:0] shadow_x [NPoints];
  logic [31:0] shadow_y [NPoints];
  logic [31:0] shadow_z [NPoints];
  int unsigned stored_count = 0;
  logic [31:0] inner_radius = 32'd0;
  logic [31:0] outer_radius = 32'd65536;

  bin_result_t pending_masks[$];
  int errors = 0;
  int beats_checked = 0;
  int points_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  radial_pair_bin_finder i_dut (.*);

  function automatic logic [65:0] square_diff(logic [31:0] a, logic [31:0] b);
    logic [33:0] d;
    logic [33:0] mag;
    logic [65:0] m;
    d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    mag = d[33] ? -d : d;
    m = 66'(mag);
    return m * m;
  endfunction

  // Works out the result beats of one point and updates the shadow store.
  task automatic predict_bins(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic fresh);
    bin_result_t r;
    logic [65:0] lo2, hi2, d2;
    logic [31:0] rmin;
    int unsigned j, groups, idx;
    bit empty_bin;
    if (fresh) stored_count = 0;
    if (stored_count >= NPoints) begin
      r = '{0, 0, '0, 1'b1, 1'b1};
      pending_masks.push_back(r);
      return;
    end
    j = stored_count;
    rmin = (inner_radius == 0) ? 32'(RminZero) : inner_radius;
    empty_bin = rmin >= outer_radius;
    lo2 = 66'(rmin) * 66'(rmin);
    hi2 = 66'(outer_radius) * 66'(outer_radius);
    groups = (j + Lanes - 1) / Lanes;
    if (groups > ResultCap) groups = ResultCap;
    if (groups == 0) begin
      r = '{IndexW'(j), 0, '0, 1'b1, 1'b0};
      pending_masks.push_back(r);
    end
    for (int g = 0; g < groups; g++) begin
      r = '{IndexW'(j), GroupW'(g), '0, (g + 1 == groups), 1'b0};
      for (int k = 0; k < Lanes; k++) begin
        idx = g * Lanes + k;
        if (idx < j && !empty_bin) begin
          d2 = square_diff(shadow_x[idx], x) + square_diff(shadow_y[idx], y)
             + square_diff(shadow_z[idx], z);
          if (d2 >= lo2 && d2 < hi2) r.match_mask[k] = 1'b1;
        end
      end
      pending_masks.push_back(r);
    end
    shadow_x[j] = x;
    shadow_y[j] = y;
    shadow_z[j] = z;
    stored_count = j + 1;
  endtask

  // Offers one point, waits for the beat, then maybe idles the sender.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic fresh);
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    new_set <= fresh;
    do @(posedge clk); while (in_stall);
    predict_bins(x, y, z, fresh);
    points_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    // The last point may still be written into the store inside the block.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_radius(logic [CfgIdxW-1:0] which, logic [31:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == RegRmin) inner_radius = value;
    else outer_radius = value;
  endtask

  function automatic logic [31:0] near(logic [31:0] c, int unsigned spread);
    return c + $urandom_range(2 * spread) - spread;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    bin_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_masks.size() == 0) begin
        $error("result beat with nothing expected: index %0d group %0d",
               point_index, group_number);
        errors++;
      end else begin
        e = pending_masks.pop_front();
        beats_checked++;
        if (point_index !== e.point_index) begin
          $error("point_index exp %0d got %0d", e.point_index, point_index);
          errors++;
        end
        if (group_number !== e.group_number) begin
          $error("group_number exp %0d got %0d", e.group_number, group_number);
          errors++;
        end
        if (match_mask !== e.match_mask) begin
          $error("match_mask exp %h got %h", e.match_mask, match_mask);
          errors++;
        end
        if (last_in_run !== e.last_in_run) begin
          $error("last_in_run exp %0b got %0b", e.last_in_run, last_in_run);
          errors++;
        end
        if (store_full !== e.store_full) begin
          $error("store_full exp %0b got %0b", e.store_full, store_full);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    int hold_left;
    if (hold_request && hold_left == 0) begin
      hold_left = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    while (quiet_cycles < Stall) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_directed();
    logic [31:0] far_pos, far_neg;
    far_pos = 32'h7fff_ffff;
    far_neg = 32'h8000_0000;
    send_point(0, 0, 0, 1'b1);          // first point of a set
    send_point(0, 0, 0, 1'b0);          // coincident, below the default floor
    send_point(66, 0, 0, 1'b0);         // exactly on the default floor
    send_point(65, 0, 0, 1'b0);
    send_point(0, 65535, 0, 1'b0);
    send_point(0, 0, 65536, 1'b0);      // outer bound is exclusive
    send_point(far_pos, far_pos, far_pos, 1'b0);
    send_point(far_neg, far_neg, far_neg, 1'b0);
    send_point(far_neg, far_pos, far_neg, 1'b0);
    send_point(32'hffff_ffff, 1, 32'hffff_0000, 1'b0);
    write_radius(RegRmax, 32'hffff_ffff);
    write_radius(RegRmin, 32'd1);
    send_point(far_pos, far_neg, 0, 1'b0);
    send_point(1, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b1);
    send_point(0, 0, 1, 1'b0);
    write_radius(RegRmin, 32'hffff_ffff);   // empty bin
    send_point(far_neg, 0, 0, 1'b0);
    send_point(far_pos, 0, 0, 1'b0);
    write_radius(RegRmin, 32'd0);
    write_radius(RegRmax, 32'd66);          // floor equals bound: empty bin
    send_point(66, 0, 0, 1'b0);
    write_radius(RegRmax, 32'd0);
    send_point(0, 0, 0, 1'b0);
  endtask

  task automatic random_points(int count);
    logic [31:0] cx, cy, cz;
    cx = $urandom; cy = $urandom; cz = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(39) == 0) begin
        cx = $urandom; cy = $urandom; cz = $urandom;
        send_point(near(cx, 1 << 17), cy, cz, 1'b1);
      end else if ($urandom_range(7) == 0) begin
        send_point($urandom, $urandom, $urandom, 1'b0);
      end else begin
        send_point(near(cx, 1 << 17), near(cy, 1 << 17), near(cz, 1 << 17), 1'b0);
      end
    end
  endtask

  task automatic test_random();
    write_radius(RegRmin, 32'd0);
    write_radius(RegRmax, 32'h0002_0000);
    send_idle_pct = 12; recv_stall_pct = 82;
    random_points(110);
    write_radius(RegRmin, $urandom_range(32'h0001_0000));
    write_radius(RegRmax, $urandom_range(32'h0001_0000, 32'h0003_0000));
    send_idle_pct = 82; recv_stall_pct = 12;
    random_points(110);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_points(70);
  endtask

  task automatic test_backpressure();
    recv_stall_pct = 20;
    hold_request = 1'b1;
    random_points(30);
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain_results();
    $display("Covered %0d points and %0d result beats: directed extremes, empty bins,",
             points_sent, beats_checked);
    $display("random clusters with set restarts under stalls and a long output hold-off.");
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: radial_pair_bin_finder.f
rtl/core/rpbf_pkg.sv
rtl/core/radial_pair_bin_finder.sv
tb/sv/tb.sv
